[design/lcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcb_pkg: shared types and constants of the layered color blender
// Fixed-point widths, blend mode codes, beat layouts and the control word
// between modules.
// ----------------------------------------------------------------------------
package lcb_pkg;

    localparam int CH_W     = 16;
    localparam int MODE_W   = 5;
    localparam int WIDE_W   = 40;
    localparam int NARROW_W = 24;
    localparam int CFG_W    = 30;
    localparam int CIDX_W   = 2;

    typedef logic signed [CH_W-1:0]   chan_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    // Input beat: flags, then the color, then the per-channel weight.
    typedef struct packed {
        logic         start_pixel;
        logic         last_item;
        chan_t        color_red;
        chan_t        color_green;
        chan_t        color_blue;
        chan_t        color_alpha;
        chan_t        weight_red;
        chan_t        weight_green;
        chan_t        weight_blue;
        chan_t        weight_alpha;
    } item_t;

    // Output beat: the finished RGBA pixel.
    typedef struct packed {
        chan_t out_red;
        chan_t out_green;
        chan_t out_blue;
        chan_t out_alpha;
    } pixel_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_COMPENSATE = 5'd0,
        MODE_MIX        = 5'd1,
        MODE_ADD        = 5'd2,
        MODE_ADD_BOUND  = 5'd3,
        MODE_MULTIPLY   = 5'd4,
        MODE_MUL_BOUND  = 5'd5,
        MODE_INTENSITY  = 5'd6,
        MODE_DARKER     = 5'd7,
        MODE_LIGHTER    = 5'd8,
        MODE_DIFFERENCE = 5'd9,
        MODE_HARD_LIGHT = 5'd10,
        MODE_HUE_OFFSET = 5'd11,
        MODE_SCREEN     = 5'd12,
        MODE_SOFT_LIGHT = 5'd13,
        MODE_DECAL      = 5'd14,
        MODE_ALPHA      = 5'd15,
        MODE_MODULATE   = 5'd16
    } mode_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_LAYER_COUNT = 2'd0,
        CFG_ENABLE_MASK = 2'd1,
        CFG_ALPHA_MASK  = 2'd2,
        CFG_LAYER_MODES = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_P,
        ST_Q,
        ST_R,
        ST_DONE
    } state_t;

    // Control word handed from the sequencer to every lane.
    typedef struct packed {
        logic [2:0]  step;
        logic [MODE_W-1:0] mode;
        logic        lum_ok;
    } lane_ctl_t;

    localparam logic [2:0] STEP_SCALE = 3'd0;
    localparam logic [2:0] STEP_P     = 3'd1;
    localparam logic [2:0] STEP_Q     = 3'd2;
    localparam logic [2:0] STEP_R     = 3'd3;
    localparam logic [2:0] STEP_HOLD  = 3'd4;

endpackage

[design/lcb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcb_if: valid/ready channel carrying one beat of payload
// Generic stream interface with source and sink views.
// ----------------------------------------------------------------------------
interface lcb_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/lcb_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcb_lane: one color channel of the blender
// Holds the running channel and applies the blend mode over the scale, P, Q and R
// steps, at most two rounded multiplies per step.
// ----------------------------------------------------------------------------
module lcb_lane #(
    parameter int FRAC_BITS = 12,
    parameter bit IS_ALPHA  = 1'b0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lcb_pkg::lane_ctl_t ctl,
    input  logic             load,
    input  lcb_pkg::chan_t   base,
    input  lcb_pkg::chan_t   color,
    input  lcb_pkg::chan_t   weight,
    input  lcb_pkg::chan_t   calpha,
    input  logic             do_scale,
    input  lcb_pkg::wide_t   lum,
    output lcb_pkg::chan_t   value
);
    import lcb_pkg::*;

    localparam logic signed [WIDE_W-1:0] ONE  = WIDE_W'(1) <<< FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [WIDE_W-1:0] QTR  = WIDE_W'(1) <<< (FRAC_BITS - 2);

    chan_t a_reg, a_next;
    wide_t w_reg, w_next;
    wide_t p_reg, p_next;
    wide_t q_reg, q_next;

    // The second operand is always a color, an alpha, the luminance or a value
    // close to ONE, so it fits the narrow width.
    function automatic wide_t fmul(input wide_t x, input logic signed [NARROW_W-1:0] y);
        logic signed [WIDE_W+NARROW_W-1:0] pr;
        begin
            pr = x * y + (WIDE_W+NARROW_W)'(HALF);
            return WIDE_W'(pr >>> FRAC_BITS);
        end
    endfunction

    function automatic chan_t sat(input wide_t x);
        begin
            if (x > 32767)
                return 16'sh7fff;
            else if (x < -32768)
                return 16'sh8000;
            return chan_t'(x);
        end
    endfunction

    function automatic wide_t unit(input wide_t x);
        begin
            if (x < 0)
                return '0;
            else if (x > ONE)
                return ONE;
            return x;
        end
    endfunction

    wide_t a_w, c_w, ca_w, v;

    assign a_w  = WIDE_W'(a_reg);
    assign c_w  = WIDE_W'(color);
    assign ca_w = WIDE_W'(calpha);

    // Multiplies are spread over steps: P builds p and w*lum or w*alpha, Q the first
    // mode product, R the final combination.
    always_comb
    begin
        w_next = w_reg;
        p_next = p_reg;
        q_next = q_reg;
        v      = a_w;
        a_next = a_reg;
        if (load)
        begin
            a_next = base;
            w_next = WIDE_W'(weight);
        end
        else
        begin
            case (ctl.step)
                STEP_SCALE:
                begin
                    w_next = do_scale ? fmul(WIDE_W'(weight), NARROW_W'(ca_w))
                                      : WIDE_W'(weight);
                end
                STEP_P:
                begin
                    p_next = fmul(w_reg, NARROW_W'(c_w));
                    if (ctl.mode == MODE_INTENSITY)
                        q_next = fmul(w_reg, NARROW_W'(lum));
                    else
                        q_next = fmul(w_reg, NARROW_W'(ca_w));
                end
                STEP_Q:
                begin
                    case (ctl.mode)
                        MODE_COMPENSATE: q_next = fmul(ONE - p_reg, NARROW_W'(a_w));
                        MODE_MIX, MODE_DECAL: q_next = fmul(ONE - w_reg, NARROW_W'(a_w));
                        MODE_INTENSITY:  q_next = fmul(ONE - q_reg, NARROW_W'(a_w));
                        MODE_MULTIPLY, MODE_MUL_BOUND, MODE_MODULATE:
                            q_next = fmul(p_reg, NARROW_W'(a_w));
                        MODE_HARD_LIGHT:
                            q_next = (c_w < HALF) ? fmul(p_reg, NARROW_W'(a_w))
                                                  : fmul(ONE - p_reg, NARROW_W'(ONE - a_w));
                        MODE_HUE_OFFSET:
                            q_next = (a_w < HALF) ? fmul(p_reg, NARROW_W'(a_w))
                                                  : fmul(ONE - p_reg, NARROW_W'(ONE - a_w));
                        MODE_SCREEN: q_next = fmul(ONE - p_reg, NARROW_W'(ONE - a_w));
                        MODE_SOFT_LIGHT: q_next = fmul(HALF, NARROW_W'(a_w)) + QTR;
                        MODE_ALPHA:
                            q_next = IS_ALPHA ? fmul(ONE - w_reg, NARROW_W'(a_w))
                                              : fmul(ONE - q_reg, NARROW_W'(a_w));
                        default: q_next = q_reg;
                    endcase
                    // second product kept in w for the modes that need it
                    case (ctl.mode)
                        MODE_MIX, MODE_DECAL: w_next = fmul(w_reg, NARROW_W'(c_w));
                        MODE_INTENSITY: w_next = fmul(q_reg, NARROW_W'(c_w));
                        MODE_ALPHA:
                            w_next = IS_ALPHA ? fmul(w_reg, NARROW_W'(c_w))
                                              : fmul(p_reg, NARROW_W'(ca_w));
                        default: w_next = w_reg;
                    endcase
                end
                STEP_R:
                begin
                    case (ctl.mode)
                        MODE_COMPENSATE: v = q_reg + p_reg;
                        MODE_MIX, MODE_INTENSITY, MODE_ALPHA: v = q_reg + w_reg;
                        MODE_DECAL: v = ctl.lum_ok ? q_reg + w_reg : a_w;
                        MODE_ADD: v = a_w + p_reg;
                        MODE_ADD_BOUND: v = unit(a_w + p_reg);
                        MODE_MULTIPLY: v = q_reg;
                        MODE_MUL_BOUND: v = unit(q_reg);
                        MODE_DARKER: v = (a_w < p_reg) ? a_w : p_reg;
                        MODE_LIGHTER: v = (a_w > p_reg) ? a_w : p_reg;
                        MODE_DIFFERENCE:
                            v = (a_w - p_reg < 0) ? p_reg - a_w : a_w - p_reg;
                        MODE_HARD_LIGHT:
                            v = (c_w < HALF) ? q_reg <<< 1 : ONE - (q_reg <<< 1);
                        MODE_HUE_OFFSET:
                            v = (a_w < HALF) ? q_reg <<< 1 : ONE - (q_reg <<< 1);
                        MODE_SCREEN: v = ONE - q_reg;
                        MODE_SOFT_LIGHT:
                            v = (p_reg < HALF) ? fmul(p_reg, NARROW_W'(q_reg)) <<< 1
                                : ONE - ((ONE - fmul(ONE - p_reg, NARROW_W'(q_reg))) <<< 1);
                        MODE_MODULATE:
                            v = (!IS_ALPHA && ctl.lum_ok) ? q_reg : a_w;
                        default: v = a_w;
                    endcase
                    a_next = sat(v);
                end
                default: a_next = a_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_reg <= '0;
        else
            a_reg <= a_next;
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        p_reg <= p_next;
        q_reg <= q_next;
    end

    assign value = a_reg;

endmodule

[design/layered_color_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_color_blend: RGBA layer blender, four channel lanes
//
//   channel   dir  beat contents
//   in_item   in   start/last flags, layer color, layer weight
//   out_pix   out  blended RGBA
//   cfg       in   write enable, register index, data
//
// A base item, and a layer item that is not blended, is taken without leaving idle.
// A blended layer item runs through alpha scale, three multiply steps in each lane
// and result capture (states SCALE, P, Q, R and DONE) before the next is taken.
// The result register holds the pixel while out is stalled; the next item
// is taken meanwhile unless it is itself a last item.
// Reset clears running color, layer position, and restores register defaults.
// ----------------------------------------------------------------------------
module layered_color_blend #(
    parameter int LAYERS    = 6,
    parameter int FRAC_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [29:0] cfg_data,
    lcb_if.sink   in_item,
    lcb_if.source out_pix
);
    import lcb_pkg::*;

    localparam logic signed [WIDE_W-1:0] ONE = WIDE_W'(1) <<< FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] L299 = WIDE_W'(((299 << FRAC_BITS) + 500) / 1000);
    localparam logic signed [WIDE_W-1:0] L587 = WIDE_W'(((587 << FRAC_BITS) + 500) / 1000);
    localparam logic signed [WIDE_W-1:0] L114 = WIDE_W'(((114 << FRAC_BITS) + 500) / 1000);
    localparam int EPS_I = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam logic signed [WIDE_W-1:0] EPS = WIDE_W'((EPS_I < 1) ? 1 : EPS_I);

    logic [2:0]  count_reg;
    logic [5:0]  enable_reg, amask_reg;
    logic [29:0] modes_reg;
    logic [2:0]  pos_reg, pos_next;
    state_t      state_reg, state_next;
    logic        last_reg, last_next;
    logic        scale_reg, scale_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    wide_t       lum_reg, lum_next;
    logic        ovalid_reg, ovalid_next;
    chan_t       o_r_reg, o_g_reg, o_b_reg, o_a_reg;
    chan_t       cr_reg, cg_reg, cb_reg, ca_reg;
    chan_t       wr_reg, wg_reg, wb_reg, wa_reg;

    logic accept, do_blend, big, load, capture;
    lane_ctl_t ctl;
    chan_t v_r, v_g, v_b, v_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 3'd2;
            enable_reg <= '0;
            amask_reg  <= '0;
            modes_reg  <= 30'd34636833;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LAYER_COUNT: count_reg  <= cfg_data[2:0];
                CFG_ENABLE_MASK: enable_reg <= cfg_data[5:0];
                CFG_ALPHA_MASK:  amask_reg  <= cfg_data[5:0];
                CFG_LAYER_MODES: modes_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic wbig(input chan_t w);
        begin
            return (WIDE_W'(w) >= EPS) || (WIDE_W'(w) <= -EPS);
        end
    endfunction

    assign big = wbig(in_item.data.weight_red) || wbig(in_item.data.weight_green)
              || wbig(in_item.data.weight_blue) || wbig(in_item.data.weight_alpha);
    assign do_blend = !in_item.data.start_pixel && (32'(pos_reg) < LAYERS)
                   && ({1'b0, pos_reg} + 4'd1 < {1'b0, count_reg})
                   && enable_reg[pos_reg] && big;

    assign in_item.ready = (state_reg == ST_IDLE) && !(ovalid_reg && in_item.data.last_item);
    assign accept = in_item.valid && in_item.ready;
    assign load   = accept && in_item.data.start_pixel;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && do_blend) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_P;
            ST_P:     state_next = ST_Q;
            ST_Q:     state_next = ST_R;
            ST_R:     state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.step   = STEP_HOLD;
        ctl.mode   = mode_reg;
        ctl.lum_ok = (lum_reg >= EPS);
        case (state_reg)
            ST_SCALE: ctl.step = STEP_SCALE;
            ST_P:     ctl.step = STEP_P;
            ST_Q:     ctl.step = STEP_Q;
            ST_R:     ctl.step = STEP_R;
            default:  ctl.step = STEP_HOLD;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        last_next  = last_reg;
        scale_next = scale_reg;
        mode_next  = mode_reg;
        lum_next   = lum_reg;
        if (accept)
        begin
            last_next = in_item.data.last_item;
            if (in_item.data.start_pixel)
                pos_next = '0;
            else if (pos_reg != 3'd7)
                pos_next = pos_reg + 3'd1;
            if (do_blend)
            begin
                scale_next = amask_reg[pos_reg];
                mode_next  = modes_reg[5*pos_reg +: MODE_W];
            end
        end
        // The luminance is ready before the P step, where intensity uses it.
        if (state_reg == ST_SCALE)
            lum_next = ((WIDE_W'(cr_reg) * L299 + (ONE >>> 1)) >>> FRAC_BITS)
                     + ((WIDE_W'(cg_reg) * L587 + (ONE >>> 1)) >>> FRAC_BITS)
                     + ((WIDE_W'(cb_reg) * L114 + (ONE >>> 1)) >>> FRAC_BITS);
    end

    // A result is captured when a non-blending last item is accepted, or when the
    // blend sequence of a last item completes.
    assign capture = (accept && in_item.data.last_item && !do_blend)
                  || (state_reg == ST_DONE && last_reg);

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_pix.valid && out_pix.ready)
            ovalid_next = 1'b0;
        if (capture)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            scale_reg  <= 1'b0;
            mode_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
            scale_reg  <= scale_next;
            mode_reg   <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lum_reg <= lum_next;
        if (accept)
        begin
            cr_reg <= in_item.data.color_red;
            cg_reg <= in_item.data.color_green;
            cb_reg <= in_item.data.color_blue;
            ca_reg <= in_item.data.color_alpha;
            wr_reg <= in_item.data.weight_red;
            wg_reg <= in_item.data.weight_green;
            wb_reg <= in_item.data.weight_blue;
            wa_reg <= in_item.data.weight_alpha;
        end
        if (capture)
        begin
            if (load)
            begin
                o_r_reg <= in_item.data.color_red;
                o_g_reg <= in_item.data.color_green;
                o_b_reg <= in_item.data.color_blue;
                o_a_reg <= in_item.data.color_alpha;
            end
            else
            begin
                o_r_reg <= v_r;
                o_g_reg <= v_g;
                o_b_reg <= v_b;
                o_a_reg <= v_a;
            end
        end
    end

    lcb_lane #(.FRAC_BITS(FRAC_BITS), .IS_ALPHA(1'b0)) u_red (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .load(load), .base(in_item.data.color_red),
        .color(cr_reg), .weight(wr_reg), .calpha(ca_reg), .do_scale(scale_reg),
        .lum(lum_reg), .value(v_r));
    lcb_lane #(.FRAC_BITS(FRAC_BITS), .IS_ALPHA(1'b0)) u_green (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .load(load), .base(in_item.data.color_green),
        .color(cg_reg), .weight(wg_reg), .calpha(ca_reg), .do_scale(scale_reg),
        .lum(lum_reg), .value(v_g));
    lcb_lane #(.FRAC_BITS(FRAC_BITS), .IS_ALPHA(1'b0)) u_blue (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .load(load), .base(in_item.data.color_blue),
        .color(cb_reg), .weight(wb_reg), .calpha(ca_reg), .do_scale(scale_reg),
        .lum(lum_reg), .value(v_b));
    lcb_lane #(.FRAC_BITS(FRAC_BITS), .IS_ALPHA(1'b1)) u_alpha (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .load(load), .base(in_item.data.color_alpha),
        .color(ca_reg), .weight(wa_reg), .calpha(ca_reg), .do_scale(scale_reg),
        .lum(lum_reg), .value(v_a));

    assign out_pix.valid           = ovalid_reg;
    assign out_pix.data.out_red    = o_r_reg;
    assign out_pix.data.out_green  = o_g_reg;
    assign out_pix.data.out_blue   = o_b_reg;
    assign out_pix.data.out_alpha  = o_a_reg;

endmodule

[tb/layered_color_blend_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_color_blend_tb: self-checking bench for the RGBA layer blender
// A queue-fed driver offers base and layer beats while a monitor predicts
// each blended pixel in Q3.12 and checks it against the output channel.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module layered_color_blend_tb;
    import lcb_pkg::*;

    localparam longint ONE     = 4096;
    localparam longint HALF    = 2048;
    localparam longint QUARTER = 1024;
    localparam longint LUM_R   = 1225;
    localparam longint LUM_G   = 2404;
    localparam longint LUM_B   = 467;
    localparam longint EPS     = 1;
    localparam int     TAIL_CYCLES = 24;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    logic [29:0] cfg_data;

    lcb_if #(.payload_t(item_t))  in_if ();
    lcb_if #(.payload_t(pixel_t)) out_if ();

    layered_color_blend u_top (
        .clk                          (clk),
        .rst_n                        (rst_n),
        .cfg_we                       (cfg_we),
        .cfg_index                    (cfg_index),
        .cfg_data                     (cfg_data),
        .in_item                      (in_if),
        .out_pix                      (out_if)
    );

    // Register copies and running state of the predictor.
    logic [2:0]  mix_size;
    logic [5:0]  enable_bits;
    logic [5:0]  alpha_bits;
    logic [29:0] mode_word;
    longint      blend_color [4];
    int          layer_idx;

    item_t  pending_items [$];
    pixel_t expected_pixels [$];
    int     failures;
    int     idle_mode;
    int     hold_req;
    int     hold_seen;
    int     hold_cnt;
    bit     in_fire;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint mulq(longint a, longint b);
        return (a * b + HALF) >>> 12;
    endfunction

    function automatic longint sat16(longint x);
        return x > 32767 ? 32767 : (x < -32768 ? -32768 : x);
    endfunction

    function automatic longint clamp_unit(longint x);
        return x < 0 ? 0 : (x > ONE ? ONE : x);
    endfunction

    function automatic longint mixq(longint a, longint b, longint w);
        return mulq(a, ONE - w) + mulq(b, w);
    endfunction

    function automatic longint hard_q(longint a, longint sel, longint w);
        if (sel < HALF)
            return 2 * mulq(w, a);
        return ONE - 2 * mulq(ONE - w, ONE - a);
    endfunction

    // Advances the running color by one beat and returns 1 when a pixel is due.
    function automatic bit blend_beat(item_t it, output pixel_t px);
        longint c [4];
        longint w [4];
        longint r [4];
        longint lum, a, p, v, s;
        bit     big;
        mode_t  md;
        c[0] = it.color_red;   c[1] = it.color_green;
        c[2] = it.color_blue;  c[3] = it.color_alpha;
        w[0] = it.weight_red;  w[1] = it.weight_green;
        w[2] = it.weight_blue; w[3] = it.weight_alpha;
        if (it.start_pixel)
        begin
            for (int i = 0; i < 4; i++)
                blend_color[i] = c[i];
            layer_idx = 0;
        end
        else
        begin
            big = 1'b0;
            for (int i = 0; i < 4; i++)
                if (w[i] >= EPS || w[i] <= -EPS)
                    big = 1'b1;
            if (layer_idx < 6 && layer_idx + 1 < int'(mix_size) && enable_bits[layer_idx]
                && big)
            begin
                if (alpha_bits[layer_idx])
                    for (int i = 0; i < 4; i++)
                        w[i] = mulq(w[i], c[3]);
                md = mode_t'(mode_word[5*layer_idx +: 5]);
                lum = mulq(LUM_R, c[0]) + mulq(LUM_G, c[1]) + mulq(LUM_B, c[2]);
                for (int i = 0; i < 4; i++)
                begin
                    a = blend_color[i];
                    p = mulq(c[i], w[i]);
                    v = a;
                    case (md)
                        MODE_COMPENSATE: v = mulq(a, ONE - p) + p;
                        MODE_MIX:        v = mixq(a, c[i], w[i]);
                        MODE_ADD:        v = a + p;
                        MODE_ADD_BOUND:  v = clamp_unit(a + p);
                        MODE_MULTIPLY:   v = mulq(a, p);
                        MODE_MUL_BOUND:  v = clamp_unit(mulq(a, p));
                        MODE_INTENSITY:  v = mixq(a, c[i], mulq(w[i], lum));
                        MODE_DARKER:     v = a < p ? a : p;
                        MODE_LIGHTER:    v = a > p ? a : p;
                        MODE_DIFFERENCE: v = a > p ? a - p : p - a;
                        MODE_HARD_LIGHT: v = hard_q(a, c[i], p);
                        MODE_HUE_OFFSET: v = hard_q(a, a, p);
                        MODE_SCREEN:     v = ONE - mulq(ONE - a, ONE - p);
                        MODE_SOFT_LIGHT:
                        begin
                            s = mulq(a, HALF) + QUARTER;
                            if (p < HALF)
                                v = 2 * mulq(s, p);
                            else
                                v = ONE - 2 * (ONE - mulq(s, ONE - p));
                        end
                        MODE_DECAL:      if (lum >= EPS) v = mixq(a, c[i], w[i]);
                        MODE_ALPHA:
                            if (i < 3)
                                v = mulq(a, ONE - mulq(w[i], c[3])) + mulq(p, c[3]);
                            else
                                v = mixq(a, c[i], w[i]);
                        MODE_MODULATE:   if (i < 3 && lum >= EPS) v = mulq(a, p);
                        default:         v = a;
                    endcase
                    r[i] = sat16(v);
                end
                for (int i = 0; i < 4; i++)
                    blend_color[i] = r[i];
            end
            if (layer_idx < 7)
                layer_idx++;
        end
        px.out_red   = chan_t'(blend_color[0]);
        px.out_green = chan_t'(blend_color[1]);
        px.out_blue  = chan_t'(blend_color[2]);
        px.out_alpha = chan_t'(blend_color[3]);
        return it.last_item;
    endfunction

    // Monitor: predicts on accepted input beats and checks output beats.
    always @(posedge clk)
    begin
        pixel_t px;
        pixel_t want;
        in_fire = rst_n && in_if.valid && in_if.ready;
        if (in_fire)
            if (blend_beat(in_if.data, px))
                expected_pixels.push_back(px);
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel %h", $time, out_if.data);
                failures++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_if.data.out_red !== want.out_red)
                begin
                    $display("%0t: red expected %h actual %h", $time, want.out_red,
                             out_if.data.out_red);
                    failures++;
                end
                if (out_if.data.out_green !== want.out_green)
                begin
                    $display("%0t: green expected %h actual %h", $time, want.out_green,
                             out_if.data.out_green);
                    failures++;
                end
                if (out_if.data.out_blue !== want.out_blue)
                begin
                    $display("%0t: blue expected %h actual %h", $time, want.out_blue,
                             out_if.data.out_blue);
                    failures++;
                end
                if (out_if.data.out_alpha !== want.out_alpha)
                begin
                    $display("%0t: alpha expected %h actual %h", $time, want.out_alpha,
                             out_if.data.out_alpha);
                    failures++;
                end
            end
        end
    end

    // Driver: a beat stays offered until it is taken.
    always @(negedge clk)
    begin
        logic  nv;
        item_t nd;
        nv = in_if.valid;
        nd = in_if.data;
        if (rst_n && (!in_if.valid || in_fire))
        begin
            nv = 1'b0;
            if (pending_items.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(99) < 9) &&
                !(idle_mode == 1 && $urandom_range(99) < 85))
            begin
                nv = 1'b1;
                nd = pending_items.pop_front();
            end
        end
        in_if.valid <= nv;
        in_if.data  <= nd;
    end

    // Receiver, with an occasional long hold-off.
    always @(negedge clk)
    begin
        logic rdy;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_cnt  = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rdy = 1'b0;
        end
        else if (idle_mode == 0)
            rdy = $urandom_range(99) >= 85;
        else if (idle_mode == 1)
            rdy = $urandom_range(99) >= 9;
        else
            rdy = 1'b1;
        out_if.ready <= rdy;
    end

    function automatic chan_t rand_q();
        case ($urandom_range(4))
            0, 1: return chan_t'($urandom);
            2:    return chan_t'($urandom_range(4096));
            3:    return chan_t'(int'($urandom_range(8192)) - 4096);
            default:
                case ($urandom_range(6))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    4: return -16'sd1;
                    5: return 16'sd2048;
                    default: return 16'sd4096;
                endcase
        endcase
    endfunction

    function automatic item_t rand_item(bit start, bit last);
        item_t it;
        it.start_pixel  = start;
        it.last_item    = last;
        it.color_red    = rand_q();
        it.color_green  = rand_q();
        it.color_blue   = rand_q();
        it.color_alpha  = rand_q();
        it.weight_red   = rand_q();
        it.weight_green = rand_q();
        it.weight_blue  = rand_q();
        it.weight_alpha = rand_q();
        if ($urandom_range(99) < 15)
        begin
            it.weight_red = '0; it.weight_green = '0; it.weight_blue = '0; it.weight_alpha = '0;
            if ($urandom_range(1))
                it.weight_blue = $urandom_range(1) ? 16'sd1 : -16'sd1;
        end
        return it;
    endfunction

    function automatic item_t fixed_item(bit start, bit last, chan_t c, chan_t w);
        item_t it;
        it.start_pixel = start;
        it.last_item   = last;
        it.color_red   = c; it.color_green  = c; it.color_blue  = c; it.color_alpha  = c;
        it.weight_red  = w; it.weight_green = w; it.weight_blue = w; it.weight_alpha = w;
        return it;
    endfunction

    // Mostly well-formed pixels of 0 to 8 layers; a tenth is loose noise.
    task automatic queue_random(int count);
        int n, layers;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                pending_items.push_back(rand_item(1'($urandom_range(1)),
                                                  1'($urandom_range(1))));
                n++;
            end
            else
            begin
                layers = $urandom_range(8);
                pending_items.push_back(rand_item(1'b1, layers == 0));
                for (int k = 0; k < layers; k++)
                    pending_items.push_back(rand_item(1'b0, k == layers - 1));
                n += layers + 1;
            end
        end
    endtask

    task automatic queue_directed();
        pending_items.push_back(fixed_item(1'b1, 1'b1, 16'sh7fff, 16'sh0));
        pending_items.push_back(fixed_item(1'b1, 1'b1, 16'sh8000, 16'sh7fff));
        pending_items.push_back(fixed_item(1'b1, 1'b0, 16'sd2048, 16'sd0));
        pending_items.push_back(fixed_item(1'b0, 1'b0, 16'sd4096, 16'sd4096));
        pending_items.push_back(fixed_item(1'b0, 1'b0, 16'sh7fff, 16'sh7fff));
        pending_items.push_back(fixed_item(1'b0, 1'b0, 16'sh8000, 16'sh8000));
        pending_items.push_back(fixed_item(1'b0, 1'b0, 16'sd1024, -16'sd1));
        pending_items.push_back(fixed_item(1'b0, 1'b0, 16'sd3000, 16'sd0));
        pending_items.push_back(fixed_item(1'b0, 1'b1, 16'sd1000, 16'sd2048));
        pending_items.push_back(fixed_item(1'b1, 1'b0, 16'sd0, 16'sd0));
        for (int k = 0; k < 9; k++)
            pending_items.push_back(fixed_item(1'b0, k == 8, 16'sd3072, 16'sd1));
        // Layers with no base beat pass the held color on unblended.
        pending_items.push_back(fixed_item(1'b0, 1'b0, 16'sd500, 16'sd4096));
        pending_items.push_back(fixed_item(1'b0, 1'b1, -16'sd500, 16'sh7fff));
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [29:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_LAYER_COUNT: mix_size    = val[2:0];
            CFG_ENABLE_MASK: enable_bits = val[5:0];
            CFG_ALPHA_MASK:  alpha_bits  = val[5:0];
            default:         mode_word   = val;
        endcase
    endtask

    task automatic settle();
        wait (pending_items.size() == 0 && expected_pixels.size() == 0 && !in_if.valid);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [29:0] pack_modes(int m0, int m1, int m2, int m3, int m4,
                                               int m5);
        return {m5[4:0], m4[4:0], m3[4:0], m2[4:0], m1[4:0], m0[4:0]};
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_LAYER_COUNT;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        failures     = 0;
        idle_mode    = 0;
        hold_req     = 0;
        hold_seen    = 0;
        hold_cnt     = 0;
        in_fire      = 1'b0;
        mix_size     = 3'd2;
        enable_bits  = '0;
        alpha_bits   = '0;
        mode_word    = 30'd34636833;
        layer_idx    = 0;
        for (int i = 0; i < 4; i++)
            blend_color[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 11; ph++)
        begin
            idle_mode = ph < 4 ? 0 : (ph < 8 ? 1 : 2);
            case (ph)
                0: ;
                1:
                begin
                    write_reg(CFG_LAYER_COUNT, 30'd7);
                    write_reg(CFG_ENABLE_MASK, 30'd63);
                    write_reg(CFG_ALPHA_MASK, 30'd0);
                    write_reg(CFG_LAYER_MODES, pack_modes(0, 1, 2, 3, 4, 5));
                end
                2:
                begin
                    write_reg(CFG_ALPHA_MASK, 30'd63);
                    write_reg(CFG_LAYER_MODES, pack_modes(6, 7, 8, 9, 10, 11));
                end
                3:
                begin
                    write_reg(CFG_ALPHA_MASK, 30'd21);
                    write_reg(CFG_LAYER_MODES, pack_modes(12, 13, 14, 15, 16, 17));
                end
                4:
                begin
                    write_reg(CFG_ALPHA_MASK, 30'd42);
                    write_reg(CFG_LAYER_MODES, pack_modes(13, 14, 15, 16, 31, 10));
                end
                5: write_reg(CFG_LAYER_COUNT, 30'd0);
                6: write_reg(CFG_LAYER_COUNT, 30'd1);
                9:
                begin
                    write_reg(CFG_LAYER_COUNT, 30'd7);
                    write_reg(CFG_ENABLE_MASK, 30'($urandom_range(63)));
                    write_reg(CFG_ALPHA_MASK, 30'($urandom_range(63)));
                    write_reg(CFG_LAYER_MODES, 30'($urandom));
                end
                10:
                begin
                    write_reg(CFG_LAYER_COUNT, 30'd3);
                    write_reg(CFG_ENABLE_MASK, 30'd0);
                    write_reg(CFG_ALPHA_MASK, 30'd63);
                    write_reg(CFG_LAYER_MODES, 30'h3fffffff);
                end
                default:
                begin
                    write_reg(CFG_LAYER_COUNT, 30'($urandom_range(7)));
                    write_reg(CFG_ENABLE_MASK, 30'($urandom_range(63)));
                    write_reg(CFG_ALPHA_MASK, 30'($urandom_range(63)));
                    write_reg(CFG_LAYER_MODES, 30'($urandom));
                end
            endcase
            if (ph == 1 || ph == 4)
                queue_directed();
            if (ph == 2 || ph == 8)
                hold_req++;
            queue_random(150);
            settle();
        end

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[sim.f]
design/lcb_pkg.sv
design/lcb_if.sv
design/lcb_lane.sv
design/layered_color_blend.sv
tb/layered_color_blend_tb.sv
